// ----- rtl/sse2_alu_pkg.sv -----
package sse2_alu_pkg;

  // Stream payload widths (fields packed from bit 0 up, padded to bytes)
  localparam int IN_W      = 264;
  localparam int OUT_W     = 136;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [3:0] {
    OP_XOR    = 4'd0,
    OP_PSRLW  = 4'd1,
    OP_PSRAW  = 4'd2,
    OP_PSLLW  = 4'd3,
    OP_PSRLD  = 4'd4,
    OP_PSRAD  = 4'd5,
    OP_PSLLD  = 4'd6,
    OP_PSRLQ  = 4'd7,
    OP_PSRAQ  = 4'd8,
    OP_PSLLQ  = 4'd9,
    OP_PSRLDQ = 4'd10,
    OP_PSLLDQ = 4'd11,
    OP_UNPCKL = 4'd12,
    OP_PMULLW = 4'd13
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_UD   = 2'd1,
    ST_NM   = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OSFXSR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FPU_EM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TS     = 2'd2;

  typedef struct packed {
    logic os_fxsr;
    logic fpu_em;
    logic ts;
  } cfg_t;

  // Decoded shift count, shared by both lanes and the merge stage
  typedef struct packed {
    logic [5:0] cnt;
    logic       big16;   // count >= 16 (also byte-shift overflow)
    logic       big32;
    logic       big64;
  } count_t;

endpackage

// ----- rtl/sse2_alu_lane.sv -----
module sse2_alu_lane (
  input  sse2_alu_pkg::op_t    op_i,
  input  sse2_alu_pkg::count_t cnt_i,
  input  logic [63:0]          dest_i,
  input  logic [63:0]          src_i,
  output logic [63:0]          res_o
);
  import sse2_alu_pkg::*;

  logic [63:0] srl16, sra16, sll16, mul16;
  logic [63:0] srl32, sra32, sll32;
  logic [63:0] srl64, sra64, sll64;

  always_comb begin
    logic [15:0] v16;
    logic [31:0] v32;
    logic [3:0]  a16;
    logic [4:0]  a32;
    logic [5:0]  a64;
    a16 = cnt_i.big16 ? 4'd15 : cnt_i.cnt[3:0];
    a32 = cnt_i.big32 ? 5'd31 : cnt_i.cnt[4:0];
    a64 = cnt_i.big64 ? 6'd63 : cnt_i.cnt[5:0];
    for (int e = 0; e < 4; e++) begin
      v16 = dest_i[16*e +: 16];
      srl16[16*e +: 16] = cnt_i.big16 ? 16'd0 : (v16 >> cnt_i.cnt[3:0]);
      sll16[16*e +: 16] = cnt_i.big16 ? 16'd0 : (v16 << cnt_i.cnt[3:0]);
      sra16[16*e +: 16] = $unsigned($signed(v16) >>> a16);
      mul16[16*e +: 16] = v16 * src_i[16*e +: 16];
    end
    for (int e = 0; e < 2; e++) begin
      v32 = dest_i[32*e +: 32];
      srl32[32*e +: 32] = cnt_i.big32 ? 32'd0 : (v32 >> cnt_i.cnt[4:0]);
      sll32[32*e +: 32] = cnt_i.big32 ? 32'd0 : (v32 << cnt_i.cnt[4:0]);
      sra32[32*e +: 32] = $unsigned($signed(v32) >>> a32);
    end
    srl64 = cnt_i.big64 ? 64'd0 : (dest_i >> cnt_i.cnt);
    sll64 = cnt_i.big64 ? 64'd0 : (dest_i << cnt_i.cnt);
    sra64 = $unsigned($signed(dest_i) >>> a64);
  end

  always_comb begin
    unique case (op_i)
      OP_XOR:    res_o = dest_i ^ src_i;
      OP_PSRLW:  res_o = srl16;
      OP_PSRAW:  res_o = sra16;
      OP_PSLLW:  res_o = sll16;
      OP_PSRLD:  res_o = srl32;
      OP_PSRAD:  res_o = sra32;
      OP_PSLLD:  res_o = sll32;
      OP_PSRLQ:  res_o = srl64;
      OP_PSRAQ:  res_o = sra64;
      OP_PSLLQ:  res_o = sll64;
      OP_PMULLW: res_o = mul16;
      default:   res_o = dest_i;  // cross-lane ops are finished in the merge stage
    endcase
  end

endmodule

// ----- rtl/sse2_alu_merge.sv -----
module sse2_alu_merge (
  input  sse2_alu_pkg::op_t     op_i,
  input  sse2_alu_pkg::cfg_t    cfg_i,
  input  sse2_alu_pkg::count_t  cnt_i,
  input  logic [1:0]            lane_size_i,
  input  logic [127:0]          dest_i,
  input  logic [63:0]           src_low_i,
  input  logic [63:0]           lane_lo_i,
  input  logic [63:0]           lane_hi_i,
  output logic [127:0]          res_o,
  output sse2_alu_pkg::status_t status_o
);
  import sse2_alu_pkg::*;

  logic [6:0]         bit_sh;
  logic [127:0]       bs_right, bs_left;
  logic [3:0][127:0]  unp;

  assign bit_sh   = {cnt_i.cnt[3:0], 3'b000};
  assign bs_right = cnt_i.big16 ? 128'd0 : (dest_i >> bit_sh);
  assign bs_left  = cnt_i.big16 ? 128'd0 : (dest_i << bit_sh);

  // Interleave low halves at granules of 1, 2, 4 and 8 bytes
  always_comb begin
    int g, pair, pos;
    for (int sz = 0; sz < 4; sz++) begin
      for (int k = 0; k < 16; k++) begin
        g    = 1 << sz;
        pair = k >> (sz + 1);
        pos  = k & ((2 << sz) - 1);
        if (pos < g) begin
          unp[sz][8*k +: 8] = dest_i[8*(pair*g + pos) +: 8];
        end else begin
          unp[sz][8*k +: 8] = src_low_i[8*(pair*g + pos - g) +: 8];
        end
      end
    end
  end

  always_comb begin
    res_o    = dest_i;
    status_o = ST_DONE;
    priority if (!cfg_i.os_fxsr || cfg_i.fpu_em) begin
      status_o = ST_UD;
    end else if (cfg_i.ts) begin
      status_o = ST_NM;
    end else begin
      unique case (op_i)
        OP_XOR, OP_PSRLW, OP_PSRAW, OP_PSLLW, OP_PSRLD, OP_PSRAD, OP_PSLLD,
        OP_PSRLQ, OP_PSRAQ, OP_PSLLQ, OP_PMULLW: begin
          res_o = {lane_hi_i, lane_lo_i};
        end
        OP_PSRLDQ: res_o = bs_right;
        OP_PSLLDQ: res_o = bs_left;
        OP_UNPCKL: res_o = unp[lane_size_i];
        default:   status_o = ST_UD;
      endcase
    end
  end

endmodule

// ----- rtl/sse2_packed_integer_alu.sv -----
// SSE2 packed integer ALU, 128-bit datapath.
// Input stream (in_t*): one transaction per instruction, carrying the opcode,
// the 128-bit destination and source operands (as 64-bit halves) and the
// unpack granule. Output stream (out_t*): one transaction per instruction with
// the 128-bit destination value and a status code (done, undefined opcode,
// device not available). On a fault the destination comes back unchanged.
// Two identical 64-bit lanes work on the halves side by side (XOR, element
// shifts, four 16x16 multipliers each); a merge stage adds the cross-lane
// byte shifts and unpack, applies the control-register checks and selects.
// An accepted transaction is registered and offered in the next cycle.
// Throughput is one transaction per cycle while the receiver takes each one,
// set by the single output register, reloaded in the same cycle it is taken.
// When the receiver stalls, hold the output register and drop in_tready
// only while it is full and not being taken.
// The cfg_* port writes OSFXSR (index 0), EM (index 1) and TS (index 2); write
// only while the block is idle. Reset (rst_n low, synchronous) empties the
// output register and clears all three control bits, so every instruction
// faults with undefined opcode until OSFXSR is set.
module sse2_packed_integer_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [sse2_alu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                                cfg_wdata,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // op[3:0], dest_low[67:4], dest_high[131:68], source_low[195:132],
  // source_high[259:196], lane_size[261:260], zero pad[263:262]
  input  logic [sse2_alu_pkg::IN_W-1:0]       in_tdata,
  // Output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_low[63:0], result_high[127:64], status[129:128], zero pad[135:130]
  output logic [sse2_alu_pkg::OUT_W-1:0]      out_tdata
);
  import sse2_alu_pkg::*;

  cfg_t         cfg_r, cfg_nxt;
  op_t          op;
  logic [63:0]  dest_low, dest_high, source_low, source_high;
  logic [1:0]   lane_size;
  count_t       cnt;
  logic         src_high_nz;
  logic [63:0]  lane_lo, lane_hi;
  logic [127:0] result;
  status_t      status;
  logic         in_acc;
  logic         out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;

  // Unpack the input transaction
  assign op          = op_t'(in_tdata[3:0]);
  assign dest_low    = in_tdata[67:4];
  assign dest_high   = in_tdata[131:68];
  assign source_low  = in_tdata[195:132];
  assign source_high = in_tdata[259:196];
  assign lane_size   = in_tdata[261:260];

  // Shift count is the whole 128-bit source; decode the overflow bounds once
  assign src_high_nz = |source_high;
  assign cnt.cnt     = source_low[5:0];
  assign cnt.big16   = src_high_nz || (|source_low[63:4]);
  assign cnt.big32   = src_high_nz || (|source_low[63:5]);
  assign cnt.big64   = src_high_nz || (|source_low[63:6]);

  // Control registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OSFXSR: cfg_nxt.os_fxsr = cfg_wdata;
        CFG_FPU_EM: cfg_nxt.fpu_em  = cfg_wdata;
        CFG_TS:     cfg_nxt.ts      = cfg_wdata;
        default:    cfg_nxt = cfg_r;  // unmapped index: ignore the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Per-half lanes
  sse2_alu_lane u_lane_lo (
    .op_i   (op),
    .cnt_i  (cnt),
    .dest_i (dest_low),
    .src_i  (source_low),
    .res_o  (lane_lo)
  );

  sse2_alu_lane u_lane_hi (
    .op_i   (op),
    .cnt_i  (cnt),
    .dest_i (dest_high),
    .src_i  (source_high),
    .res_o  (lane_hi)
  );

  // Cross-lane ops, fault checks and final selection
  sse2_alu_merge u_merge (
    .op_i        (op),
    .cfg_i       (cfg_r),
    .cnt_i       (cnt),
    .lane_size_i (lane_size),
    .dest_i      ({dest_high, dest_low}),
    .src_low_i   (source_low),
    .lane_lo_i   (lane_lo),
    .lane_hi_i   (lane_hi),
    .res_o       (result),
    .status_o    (status)
  );

  // Output register: accept whenever it is empty or being taken this cycle
  assign in_tready     = !out_valid_r || out_tready;
  assign in_acc        = in_tvalid && in_tready;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {6'd0, status, result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted transaction is always offered on the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted transaction not presented at output");

  // Disabled OSFXSR or set EM must fault with undefined opcode
  a_ud_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (!cfg_r.os_fxsr || cfg_r.fpu_em))
      |=> (out_tdata[129:128] == ST_UD))
    else $error("control-register check did not raise undefined opcode");

  // A faulted instruction returns the destination unchanged
  a_fault_keeps_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (!cfg_r.os_fxsr || cfg_r.fpu_em || cfg_r.ts))
      |=> (out_tdata[127:0] == $past(in_tdata[131:4])))
    else $error("faulted instruction altered the destination");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
